### rtl/core/esc_pkg.sv
package esc_pkg;

	localparam int NumStages = 12;

	localparam logic [11:0] BaseYear    = 12'd2000;
	localparam logic [11:0] CenturyNext = 12'd2100;
	localparam logic [9:0]  DayUnits    = 10'd675;   // seconds per day over 128
	localparam logic [8:0]  YearDays    = 9'd365;
	localparam logic [11:0] SecsPerHour = 12'd3600;
	localparam logic [11:0] SecsPerMin  = 12'd60;
	localparam logic [11:0] DaysPerWeek = 12'd7;

	localparam logic [22:0] DayRecip  = 23'((64'd1 << 32) / 64'd675);
	localparam logic [15:0] YearRecip = 16'((32'd1 << 24) / 32'd365);
	localparam logic [12:0] HourRecip = 13'((32'd1 << 24) / 32'd3600);
	localparam logic [10:0] MinRecip  = 11'((32'd1 << 16) / 32'd60);
	localparam logic [13:0] WeekRecip = 14'((32'd1 << 16) / 32'd7);

	typedef logic [NumStages-1:0] stage_en_t;

	typedef struct packed {
		logic [31:0] epoch_seconds;
	} epoch_in_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  day_of_month;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  sec_of_minute;
		logic [2:0]  weekday;
	} calendar_t;

	typedef struct packed {
		logic [15:0] dayno;
		logic [16:0] tod;
	} day_split_t;

	typedef struct packed {
		logic [11:0] year;
		logic [3:0]  month;
		logic [4:0]  mday;
		logic [4:0]  hour;
		logic [5:0]  min_q;
		logic [6:0]  min_r;
	} date_time_t;

	function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
		logic [8:0] base;
		case (idx)
			4'd0:    base = 9'd31;
			4'd1:    base = 9'd59;
			4'd2:    base = 9'd90;
			4'd3:    base = 9'd120;
			4'd4:    base = 9'd151;
			4'd5:    base = 9'd181;
			4'd6:    base = 9'd212;
			4'd7:    base = 9'd243;
			4'd8:    base = 9'd273;
			4'd9:    base = 9'd304;
			4'd10:   base = 9'd334;
			default: base = 9'd365;
		endcase
		return base + 9'(leap && (idx != 4'd0));
	endfunction

	// 3 * (m + 1) / 5 for the shifted month 3..14
	function automatic logic [3:0] month_term(input logic [3:0] m);
		logic [3:0] t;
		case (m)
			4'd3:    t = 4'd2;
			4'd4:    t = 4'd3;
			4'd5:    t = 4'd3;
			4'd6:    t = 4'd4;
			4'd7:    t = 4'd4;
			4'd8:    t = 4'd5;
			4'd9:    t = 4'd6;
			4'd10:   t = 4'd6;
			4'd11:   t = 4'd7;
			4'd12:   t = 4'd7;
			4'd13:   t = 4'd8;
			4'd14:   t = 4'd9;
			default: t = 4'd0;
		endcase
		return t;
	endfunction

endpackage

### rtl/core/esc_stream_if.sv
interface esc_stream_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

### rtl/core/esc_day_split.sv
module esc_day_split (
	input  logic                clk,
	input  esc_pkg::stage_en_t  en,
	input  logic [31:0]         secs,
	output esc_pkg::day_split_t split
);

	logic [47:0] prod_s1;
	logic [24:0] hi_s1;
	logic [6:0]  lo_s1;
	logic [15:0] qd_s2;
	logic [10:0] rd_s2;
	logic [6:0]  lo_s2;
	logic [15:0] dayno_s3;
	logic [16:0] tod_s3;
	logic [10:0] rd_corr;

	assign rd_corr = rd_s2 - 11'(esc_pkg::DayUnits);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			prod_s1 <= 48'(secs[31:7]) * 48'(esc_pkg::DayRecip);
			hi_s1   <= secs[31:7];
			lo_s1   <= secs[6:0];
		end
		if (en[1]) begin
			qd_s2 <= prod_s1[47:32];
			rd_s2 <= 11'(hi_s1 - 25'(prod_s1[47:32]) * 25'(esc_pkg::DayUnits));
			lo_s2 <= lo_s1;
		end
		if (en[2]) begin
			if (rd_s2 >= 11'(esc_pkg::DayUnits)) begin
				dayno_s3 <= qd_s2 + 16'd2;
				tod_s3   <= {rd_corr[9:0], lo_s2};
			end else begin
				dayno_s3 <= qd_s2 + 16'd1;
				tod_s3   <= {rd_s2[9:0], lo_s2};
			end
		end
	end

	assign split.dayno = dayno_s3;
	assign split.tod   = tod_s3;

endmodule

### rtl/core/esc_date_time.sv
module esc_date_time (
	input  logic                clk,
	input  esc_pkg::stage_en_t  en,
	input  esc_pkg::day_split_t split,
	output esc_pkg::date_time_t dt
);

	logic [31:0] p2_s4;
	logic [29:0] p3_s4;
	logic [15:0] dayno_s4;
	logic [16:0] tod_s4;

	logic [7:0]  yq_s5;
	logic [9:0]  yr_s5;
	logic [4:0]  hq_s5;
	logic [12:0] hr_s5;

	logic [11:0] year_s6;
	logic [5:0]  leaps_s6;
	logic [8:0]  rem_s6;
	logic [4:0]  hour_s6;
	logic [11:0] tod2_s6;

	logic [11:0] year_s7;
	logic        leap_s7;
	logic [8:0]  rem_s7;
	logic [4:0]  hour_s7;
	logic [22:0] p4_s7;
	logic [11:0] tod2_s7;

	logic [11:0] year_s8;
	logic [3:0]  month_s8;
	logic [4:0]  mday_s8;
	logic [4:0]  hour_s8;
	logic [5:0]  mq_s8;
	logic [6:0]  mr_s8;

	logic [7:0]  yidx_c;
	logic [9:0]  yrem_w;
	logic [4:0]  hour_c;
	logic [12:0] hrem_w;
	logic [11:0] year_c;
	logic        leap_c;
	logic [9:0]  rem_w;
	logic [3:0]  idx_c;
	logic [8:0]  mday_w;

	always_comb begin
		if (yr_s5 >= 10'(esc_pkg::YearDays)) begin
			yidx_c = yq_s5 + 8'd1;
			yrem_w = yr_s5 - 10'(esc_pkg::YearDays);
		end else begin
			yidx_c = yq_s5;
			yrem_w = yr_s5;
		end
		if (hr_s5 >= 13'(esc_pkg::SecsPerHour)) begin
			hour_c = hq_s5 + 5'd1;
			hrem_w = hr_s5 - 13'(esc_pkg::SecsPerHour);
		end else begin
			hour_c = hq_s5;
			hrem_w = hr_s5;
		end
	end

	// back off one year when the remainder falls inside the leap days passed
	always_comb begin
		if (rem_s6 <= 9'(leaps_s6)) begin
			year_c = year_s6 - 12'd1;
			leap_c = (year_c[1:0] == 2'b00);
			rem_w  = 10'(rem_s6) + 10'(esc_pkg::YearDays) + 10'(leap_c) - 10'(leaps_s6);
		end else begin
			year_c = year_s6;
			leap_c = (year_s6[1:0] == 2'b00);
			rem_w  = 10'(rem_s6) - 10'(leaps_s6);
		end
	end

	always_comb begin
		idx_c = 4'd11;
		for (int i = 10; i >= 0; i--) begin
			if (rem_s7 <= esc_pkg::cum_days(leap_s7, 4'(i))) begin
				idx_c = 4'(i);
			end
		end
		if (idx_c == 4'd0) begin
			mday_w = rem_s7;
		end else begin
			mday_w = rem_s7 - esc_pkg::cum_days(leap_s7, idx_c - 4'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			p2_s4    <= 32'(split.dayno) * 32'(esc_pkg::YearRecip);
			p3_s4    <= 30'(split.tod) * 30'(esc_pkg::HourRecip);
			dayno_s4 <= split.dayno;
			tod_s4   <= split.tod;
		end
		if (en[4]) begin
			yq_s5 <= p2_s4[31:24];
			yr_s5 <= 10'(dayno_s4 - 16'(p2_s4[31:24]) * 16'(esc_pkg::YearDays));
			hq_s5 <= p3_s4[28:24];
			hr_s5 <= 13'(tod_s4 - 17'(p3_s4[28:24]) * 17'(esc_pkg::SecsPerHour));
		end
		if (en[5]) begin
			year_s6  <= 12'(yidx_c) + esc_pkg::BaseYear;
			leaps_s6 <= 6'((9'(yidx_c) + 9'd3) >> 2);
			rem_s6   <= yrem_w[8:0];
			hour_s6  <= hour_c;
			tod2_s6  <= hrem_w[11:0];
		end
		if (en[6]) begin
			year_s7 <= year_c;
			leap_s7 <= leap_c;
			rem_s7  <= rem_w[8:0];
			hour_s7 <= hour_s6;
			p4_s7   <= 23'(tod2_s6) * 23'(esc_pkg::MinRecip);
			tod2_s7 <= tod2_s6;
		end
		if (en[7]) begin
			year_s8  <= year_s7;
			month_s8 <= idx_c + 4'd1;
			mday_s8  <= mday_w[4:0];
			hour_s8  <= hour_s7;
			mq_s8    <= p4_s7[21:16];
			mr_s8    <= 7'(tod2_s7 - 12'(p4_s7[21:16]) * esc_pkg::SecsPerMin);
		end
	end

	assign dt.year  = year_s8;
	assign dt.month = month_s8;
	assign dt.mday  = mday_s8;
	assign dt.hour  = hour_s8;
	assign dt.min_q = mq_s8;
	assign dt.min_r = mr_s8;

endmodule

### rtl/core/esc_weekday.sv
module esc_weekday (
	input  logic                clk,
	input  esc_pkg::stage_en_t  en,
	input  esc_pkg::date_time_t dt,
	output esc_pkg::calendar_t  cal
);

	esc_pkg::calendar_t cal_s9, cal_s10, cal_s11, cal_s12;
	logic [6:0]  base_s9;
	logic [11:0] yw_s9;
	logic [4:0]  cent_s9;
	logic [11:0] sum_s10;
	logic [11:0] sum_s11;
	logic [25:0] p5_s11;

	logic        early_c;
	logic [3:0]  mw_c;
	logic [11:0] yw_c;
	logic [6:0]  sec_w;
	logic [3:0]  r_w;
	logic [3:0]  r_c;

	always_comb begin
		early_c = (dt.month < 4'd3);
		mw_c    = early_c ? (dt.month + 4'd12) : dt.month;
		yw_c    = early_c ? (dt.year - 12'd1) : dt.year;
		sec_w   = dt.min_r - 7'(esc_pkg::SecsPerMin);
	end

	always_comb begin
		r_w = 4'(sum_s11 - 12'(p5_s11[25:16]) * esc_pkg::DaysPerWeek);
		r_c = (r_w >= 4'(esc_pkg::DaysPerWeek)) ? (r_w - 4'(esc_pkg::DaysPerWeek)) : r_w;
	end

	always_ff @(posedge clk) begin
		if (en[8]) begin
			cal_s9.year         <= dt.year;
			cal_s9.month        <= dt.month;
			cal_s9.day_of_month <= dt.mday;
			cal_s9.hour         <= dt.hour;
			cal_s9.weekday      <= 3'd0;
			if (dt.min_r >= 7'(esc_pkg::SecsPerMin)) begin
				cal_s9.minute        <= dt.min_q + 6'd1;
				cal_s9.sec_of_minute <= sec_w[5:0];
			end else begin
				cal_s9.minute        <= dt.min_q;
				cal_s9.sec_of_minute <= dt.min_r[5:0];
			end
			base_s9 <= 7'(dt.mday) + 7'({mw_c, 1'b0}) + 7'(esc_pkg::month_term(mw_c));
			yw_s9   <= yw_c;
			// y/100 - y/400 over the reachable years
			cent_s9 <= (yw_c >= esc_pkg::CenturyNext) ? 5'd16 : 5'd15;
		end
		if (en[9]) begin
			cal_s10 <= cal_s9;
			sum_s10 <= 12'(base_s9) + yw_s9 + (yw_s9 >> 2) - 12'(cent_s9);
		end
		if (en[10]) begin
			cal_s11 <= cal_s10;
			sum_s11 <= sum_s10;
			p5_s11  <= 26'(sum_s10) * 26'(esc_pkg::WeekRecip);
		end
		if (en[11]) begin
			cal_s12.year          <= cal_s11.year;
			cal_s12.month         <= cal_s11.month;
			cal_s12.day_of_month  <= cal_s11.day_of_month;
			cal_s12.hour          <= cal_s11.hour;
			cal_s12.minute        <= cal_s11.minute;
			cal_s12.sec_of_minute <= cal_s11.sec_of_minute;
			cal_s12.weekday       <= 3'(r_c + 4'd1);
		end
	end

	assign cal = cal_s12;

endmodule

### rtl/core/epoch_seconds_to_calendar_unit.sv
// channel | role   | payload
// stamp   | sink   | epoch_seconds
// cal     | source | year, month, day_of_month, hour, minute, sec_of_minute, weekday
//
// Twelve register stages; one transaction per cycle while cal is not stalled.
// Depth is set by the reciprocal multiplies (day, year, hour, minute, weekday)
// and the correction step that follows each one.
// arst_n clears the stage valid bits only.
// Each stage advances when it is empty or the stage after it advances, so
// bubbles fill while the output is stalled and nothing is dropped or repeated.
module epoch_seconds_to_calendar_unit (
	input  logic         clk,
	input  logic         arst_n,
	esc_stream_if.sink   stamp,
	esc_stream_if.source cal
);

	localparam int N = esc_pkg::NumStages;

	esc_pkg::stage_en_t  en;
	logic [N-1:0]        v_q;
	esc_pkg::day_split_t split;
	esc_pkg::date_time_t dt;
	esc_pkg::calendar_t  cal_w;
	esc_pkg::epoch_in_t  stamp_w;

	assign stamp_w = stamp.data;

	always_comb begin
		en[N-1] = !v_q[N-1] || cal.ready;
		for (int k = N - 2; k >= 0; k--) begin
			en[k] = !v_q[k] || en[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			if (en[0]) begin
				v_q[0] <= stamp.valid;
			end
			for (int k = 1; k < N; k++) begin
				if (en[k]) begin
					v_q[k] <= v_q[k-1];
				end
			end
		end
	end

	esc_day_split u_split (
		.clk   (clk),
		.en    (en),
		.secs  (stamp_w.epoch_seconds),
		.split (split)
	);

	esc_date_time u_date (
		.clk   (clk),
		.en    (en),
		.split (split),
		.dt    (dt)
	);

	esc_weekday u_week (
		.clk (clk),
		.en  (en),
		.dt  (dt),
		.cal (cal_w)
	);

	assign stamp.ready = en[0];
	assign cal.valid   = v_q[N-1];
	assign cal.data    = cal_w;

	a_full_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		((&v_q) && !cal.ready) |-> !stamp.ready)
		else $error("input taken while every stage is full and output stalled");

	a_date_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal.valid |-> (cal.data.month >= 4'd1 && cal.data.month <= 4'd12 &&
			cal.data.day_of_month >= 5'd1 && cal.data.year >= 12'd2000 &&
			cal.data.year <= 12'd2136))
		else $error("date field out of range");

	a_time_range: assert property (@(posedge clk) disable iff (!arst_n)
		cal.valid |-> (cal.data.hour <= 5'd23 && cal.data.minute <= 6'd59 &&
			cal.data.sec_of_minute <= 6'd59 && cal.data.weekday >= 3'd1))
		else $error("time or weekday field out of range");

endmodule
